// ===== design/rmq_pkg.sv =====
// Shared types and constants of the rotation matrix to quaternion unit.
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;
	localparam int DATA_W        = 16;
	localparam int FRAC_BITS_DEF = 14;
	localparam int LANES         = 4;
	localparam int V_W           = 34;
	localparam int MAG_W         = 32;
	localparam int SUM_W         = 64;
	localparam int SH_W          = 5;
	localparam int Q_W           = 32;
	localparam int NORM_BIT      = 29;
	localparam int QUEUE_DEPTH   = 4;

	typedef enum logic [1:0] {
		CASE_TRACE = 2'd0,
		CASE_X     = 2'd1,
		CASE_Y     = 2'd2,
		CASE_Z     = 2'd3
	} case_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] xaxis_x;
		logic signed [DATA_W-1:0] xaxis_y;
		logic signed [DATA_W-1:0] xaxis_z;
		logic signed [DATA_W-1:0] yaxis_x;
		logic signed [DATA_W-1:0] yaxis_y;
		logic signed [DATA_W-1:0] yaxis_z;
		logic signed [DATA_W-1:0] zaxis_x;
		logic signed [DATA_W-1:0] zaxis_y;
		logic signed [DATA_W-1:0] zaxis_z;
	} matrix_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] quat_w;
		logic signed [DATA_W-1:0] quat_x;
		logic signed [DATA_W-1:0] quat_y;
		logic signed [DATA_W-1:0] quat_z;
		logic [1:0]               case_taken;
		logic                     invalid;
	} quat_t;

	typedef struct packed {
		logic [LANES-1:0] neg;
		case_t            kase;
		logic             invalid;
	} tag_t;

	typedef struct packed {
		logic [LANES-1:0][MAG_W-1:0] mag;
		tag_t                        tag;
	} cls_t;
endpackage
`default_nettype wire

// ===== design/rmq_chan_if.sv =====
// Valid/ready channel that carries one word of a given payload type.
`timescale 1ns / 1ps
`default_nettype none
interface rmq_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/rmq_front.sv =====
// Front end: takes a matrix word, picks the branch and forms the branch vector.
`timescale 1ns / 1ps
`default_nettype none
module rmq_front #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	rmq_chan_if.sink           matrix,
	output      logic          push_valid,
	output      rmq_pkg::cls_t push_data,
	input  wire logic          push_ready
);
	localparam logic signed [rmq_pkg::V_W-1:0] ONE = rmq_pkg::V_W'(1) << FRAC_BITS;

	logic signed [rmq_pkg::V_W-1:0] xx, xy, xz, yx, yy, yz, zx, zy, zz, tr, r;
	logic signed [rmq_pkg::V_W-1:0] v [rmq_pkg::LANES];
	rmq_pkg::cls_t cls_c, cls_s1;
	logic valid_s1, ready;

	assign xx = rmq_pkg::V_W'(matrix.data.xaxis_x);
	assign xy = rmq_pkg::V_W'(matrix.data.xaxis_y);
	assign xz = rmq_pkg::V_W'(matrix.data.xaxis_z);
	assign yx = rmq_pkg::V_W'(matrix.data.yaxis_x);
	assign yy = rmq_pkg::V_W'(matrix.data.yaxis_y);
	assign yz = rmq_pkg::V_W'(matrix.data.yaxis_z);
	assign zx = rmq_pkg::V_W'(matrix.data.zaxis_x);
	assign zy = rmq_pkg::V_W'(matrix.data.zaxis_y);
	assign zz = rmq_pkg::V_W'(matrix.data.zaxis_z);
	assign tr = xx + yy + zz;

	always_comb begin
		if (tr > 0) begin
			cls_c.tag.kase = rmq_pkg::CASE_TRACE;
			r = ONE + tr;
			v[0] = r; v[1] = zy - yz; v[2] = xz - zx; v[3] = yx - xy;
		end else if (xx > yy && xx > zz) begin
			cls_c.tag.kase = rmq_pkg::CASE_X;
			r = ONE + xx - yy - zz;
			v[0] = zy - yz; v[1] = r; v[2] = xy + yx; v[3] = xz + zx;
		end else if (yy > zz) begin
			cls_c.tag.kase = rmq_pkg::CASE_Y;
			r = ONE + yy - xx - zz;
			v[0] = xz - zx; v[1] = xy + yx; v[2] = r; v[3] = yz + zy;
		end else begin
			cls_c.tag.kase = rmq_pkg::CASE_Z;
			r = ONE + zz - xx - yy;
			v[0] = yx - xy; v[1] = xz + zx; v[2] = yz + zy; v[3] = r;
		end
		cls_c.tag.invalid = (r <= 0);
		for (int i = 0; i < rmq_pkg::LANES; i++) begin
			cls_c.tag.neg[i] = v[i][rmq_pkg::V_W-1];
			cls_c.mag[i] = v[i][rmq_pkg::V_W-1] ? rmq_pkg::MAG_W'(-v[i])
				: rmq_pkg::MAG_W'(v[i]);
		end
	end

	assign ready        = !valid_s1 || push_ready;
	assign matrix.ready = ready;
	assign push_valid   = valid_s1;
	assign push_data    = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= matrix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && matrix.valid) begin
			cls_s1 <= cls_c;
		end
	end
endmodule
`default_nettype wire

// ===== design/rmq_queue.sv =====
// Short FIFO that decouples the classifying front from the arithmetic back.
`timescale 1ns / 1ps
`default_nettype none
module rmq_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	input  wire rmq_pkg::cls_t push_data,
	output      logic          push_ready,
	output      logic          pop_valid,
	output      rmq_pkg::cls_t pop_data,
	input  wire logic          pop
);
	localparam int PTR_W = $clog2(rmq_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(rmq_pkg::QUEUE_DEPTH + 1);

	rmq_pkg::cls_t mem_q [rmq_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign push_ready = (cnt_q != CNT_W'(rmq_pkg::QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

// ===== design/rmq_back.sv =====
// Back end: normalize shift, sum of squares, square root, four divides, output word.
`timescale 1ns / 1ps
`default_nettype none
module rmq_back #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pop_valid,
	input  wire rmq_pkg::cls_t pop_data,
	output      logic          pop,
	rmq_chan_if.source         quaternion
);
	localparam int L      = rmq_pkg::LANES;
	localparam int MW     = rmq_pkg::MAG_W;
	localparam int SW     = rmq_pkg::SUM_W;
	localparam int QW     = rmq_pkg::Q_W;
	localparam int SQ_N   = SW / 2;
	localparam int DIV_N  = FRAC_BITS + 1;

	logic en;
	logic ovalid_q;
	rmq_pkg::quat_t oword_q, oword_c;

	// The whole pipeline moves together unless the output word is held.
	assign en  = !ovalid_q || quaternion.ready;
	assign pop = en;

	// Stage 1: word from the queue.
	logic valid_s1;
	rmq_pkg::cls_t cls_s1;
	// Stage 2: normalize shift amount.
	logic valid_s2;
	rmq_pkg::cls_t cls_s2;
	logic [rmq_pkg::SH_W-1:0] sh_s2, sh_c;
	logic [MW-1:0] orv;
	// Stage 3: shifted magnitudes.
	logic valid_s3;
	logic [L-1:0][MW-1:0] mag_s3;
	rmq_pkg::tag_t tag_s3;
	// Stage 4: squares.
	logic valid_s4;
	logic [L-1:0][MW-1:0] mag_s4;
	logic [L-1:0][SW-1:0] sq_s4;
	rmq_pkg::tag_t tag_s4;
	// Square root pipeline, one result bit per stage; entry 0 is the sum.
	logic               sv [SQ_N+1];
	logic [SW-1:0]      sx [SQ_N+1];
	logic [SW-1:0]      sr [SQ_N+1];
	logic [L-1:0][MW-1:0] smag [SQ_N+1];
	rmq_pkg::tag_t      stag [SQ_N+1];
	// Dividend stage.
	logic valid_s5;
	logic [L-1:0][SW-1:0] num_s5;
	logic [MW-1:0] n_s5;
	rmq_pkg::tag_t tag_s5;
	// Divide pipeline, one quotient bit per stage in all four lanes.
	logic                 dv [DIV_N+1];
	logic [L-1:0][SW-1:0] drem [DIV_N+1];
	logic [L-1:0][QW-1:0] dq [DIV_N+1];
	logic [MW-1:0]        dn [DIV_N+1];
	rmq_pkg::tag_t        dtag [DIV_N+1];

	always_comb begin
		orv = cls_s1.mag[0] | cls_s1.mag[1] | cls_s1.mag[2] | cls_s1.mag[3];
		sh_c = '0;
		if (orv[MW-1:rmq_pkg::NORM_BIT] == '0) begin
			for (int i = 0; i < rmq_pkg::NORM_BIT; i++) begin
				if (orv[i]) sh_c = rmq_pkg::SH_W'(rmq_pkg::NORM_BIT - i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pop_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= sv[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s1 <= pop_data;
			cls_s2 <= cls_s1;
			sh_s2  <= sh_c;
			tag_s3 <= cls_s2.tag;
			tag_s4 <= tag_s3;
			mag_s4 <= mag_s3;
			for (int i = 0; i < L; i++) begin
				mag_s3[i] <= cls_s2.mag[i] << sh_s2;
				sq_s4[i]  <= SW'(mag_s3[i]) * SW'(mag_s3[i]);
			end
			n_s5   <= MW'(sr[SQ_N]);
			tag_s5 <= stag[SQ_N];
			for (int i = 0; i < L; i++) begin
				num_s5[i] <= (SW'(smag[SQ_N][i]) << FRAC_BITS) + SW'(sr[SQ_N] >> 1);
			end
		end
	end

	assign sv[0]   = valid_s4;
	assign sx[0]   = sq_s4[0] + sq_s4[1] + sq_s4[2] + sq_s4[3];
	assign sr[0]   = '0;
	assign smag[0] = mag_s4;
	assign stag[0] = tag_s4;

	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * k);
		logic [SW-1:0] trial;
		assign trial = sr[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv[k+1] <= 1'b0;
			end else if (en) begin
				sv[k+1] <= sv[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				smag[k+1] <= smag[k];
				stag[k+1] <= stag[k];
				if (sx[k] >= trial) begin
					sx[k+1] <= sx[k] - trial;
					sr[k+1] <= (sr[k] >> 1) + BIT;
				end else begin
					sx[k+1] <= sx[k];
					sr[k+1] <= sr[k] >> 1;
				end
			end
		end
	end

	assign dv[0]   = valid_s5;
	assign drem[0] = num_s5;
	assign dq[0]   = '0;
	assign dn[0]   = n_s5;
	assign dtag[0] = tag_s5;

	for (genvar j = 0; j < DIV_N; j++) begin : g_div
		logic [SW-1:0] dsr;
		assign dsr = SW'(dn[j]) << (FRAC_BITS - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[j+1] <= 1'b0;
			end else if (en) begin
				dv[j+1] <= dv[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dn[j+1]   <= dn[j];
				dtag[j+1] <= dtag[j];
				for (int i = 0; i < L; i++) begin
					if (drem[j][i] >= dsr) begin
						drem[j+1][i] <= drem[j][i] - dsr;
						dq[j+1][i]   <= {dq[j][i][QW-2:0], 1'b1};
					end else begin
						drem[j+1][i] <= drem[j][i];
						dq[j+1][i]   <= {dq[j][i][QW-2:0], 1'b0};
					end
				end
			end
		end
	end

	// Sign, conjugate and saturate each part.
	logic signed [QW:0] sval [L];
	logic signed [rmq_pkg::DATA_W-1:0] part [L];
	always_comb begin
		for (int i = 0; i < L; i++) begin
			sval[i] = (dtag[DIV_N].neg[i] ^ (i != 0)) ? -$signed({1'b0, dq[DIV_N][i]})
				: $signed({1'b0, dq[DIV_N][i]});
			if (sval[i] > (QW+1)'(32767)) part[i] = 16'sd32767;
			else if (sval[i] < -(QW+1)'(32768)) part[i] = -16'sd32768;
			else part[i] = rmq_pkg::DATA_W'(sval[i]);
			if (dtag[DIV_N].invalid) part[i] = '0;
		end
		oword_c.quat_w     = part[0];
		oword_c.quat_x     = part[1];
		oword_c.quat_y     = part[2];
		oword_c.quat_z     = part[3];
		oword_c.case_taken = dtag[DIV_N].kase;
		oword_c.invalid    = dtag[DIV_N].invalid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (en) begin
			ovalid_q <= dv[DIV_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oword_q <= oword_c;
		end
	end

	assign quaternion.valid = ovalid_q;
	assign quaternion.data  = oword_q;
endmodule
`default_nettype wire

// ===== design/rotation_matrix_to_quaternion_unit.sv =====
// Top level: rotation matrix to unit conjugated quaternion converter.
// Throughput is one word per cycle while the output word is not held; a 32-stage square root
// and a FRAC_BITS + 1 stage divider set the depth of the back end pipeline.
// A four-word queue sits between the classifying front and the arithmetic back.
// Reset clears all valid flags and queue pointers; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_unit #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	rmq_chan_if.sink   matrix,
	rmq_chan_if.source quaternion
);
	logic          push_valid, push_ready, pop_valid, pop;
	rmq_pkg::cls_t push_data, pop_data;

	rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.matrix     (matrix),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	rmq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop        (pop)
	);

	rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop        (pop),
		.quaternion (quaternion)
	);
endmodule
`default_nettype wire

// ===== sim/rotation_matrix_to_quaternion_unit_tb.sv =====
// Self-checking testbench of the rotation matrix to quaternion unit.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_quaternion_unit_tb;
	localparam int FRAC = rmq_pkg::FRAC_BITS_DEF;
	localparam int LATENCY = FRAC + 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors = 0;

	always #4 clk = ~clk;

	rmq_chan_if #(.payload_t(rmq_pkg::matrix_t)) matrix_ch();
	rmq_chan_if #(.payload_t(rmq_pkg::quat_t)) quat_ch();

	rotation_matrix_to_quaternion_unit #(.FRAC_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.matrix(matrix_ch.sink),
		.quaternion(quat_ch.source)
	);

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
	endtask

	function automatic logic [63:0] isqrt(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic rmq_pkg::quat_t convert(input rmq_pkg::matrix_t m);
		rmq_pkg::quat_t q;
		longint xx, xy, xz, yx, yy, yz, zx, zy, zz, r, one, s;
		longint v[4];
		logic [63:0] mag[4];
		logic [63:0] mx, sum, n, d;
		xx = m.xaxis_x; xy = m.xaxis_y; xz = m.xaxis_z;
		yx = m.yaxis_x; yy = m.yaxis_y; yz = m.yaxis_z;
		zx = m.zaxis_x; zy = m.zaxis_y; zz = m.zaxis_z;
		one = longint'(1) << FRAC;
		if (xx + yy + zz > 0) begin
			q.case_taken = rmq_pkg::CASE_TRACE; r = one + xx + yy + zz;
			v[0] = r; v[1] = zy - yz; v[2] = xz - zx; v[3] = yx - xy;
		end else if (xx > yy && xx > zz) begin
			q.case_taken = rmq_pkg::CASE_X; r = one + xx - yy - zz;
			v[0] = zy - yz; v[1] = r; v[2] = xy + yx; v[3] = xz + zx;
		end else if (yy > zz) begin
			q.case_taken = rmq_pkg::CASE_Y; r = one + yy - xx - zz;
			v[0] = xz - zx; v[1] = xy + yx; v[2] = r; v[3] = yz + zy;
		end else begin
			q.case_taken = rmq_pkg::CASE_Z; r = one + zz - xx - yy;
			v[0] = yx - xy; v[1] = xz + zx; v[2] = yz + zy; v[3] = r;
		end
		q.quat_w = '0; q.quat_x = '0; q.quat_y = '0; q.quat_z = '0;
		q.invalid = (r <= 0);
		if (q.invalid) return q;
		mx = 0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = v[i] < 0 ? -v[i] : v[i];
			if (mag[i] > mx) mx = mag[i];
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 4; i++) mag[i] <<= 1;
		end
		sum = 0;
		for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
		n = isqrt(sum);
		for (int i = 0; i < 4; i++) begin
			d = ((mag[i] << FRAC) + (n >> 1)) / n;
			s = longint'(d);
			if (v[i] < 0) s = -s;
			if (i != 0) s = -s;
			if (s > 32767) s = 32767;
			if (s < -32768) s = -32768;
			case (i)
				0: q.quat_w = s[15:0];
				1: q.quat_x = s[15:0];
				2: q.quat_y = s[15:0];
				default: q.quat_z = s[15:0];
			endcase
		end
		return q;
	endfunction

	class quat_scoreboard;
		rmq_pkg::quat_t pending[$];
		int checked = 0;
		int invalid_seen = 0;
		int case_seen[4] = '{0, 0, 0, 0};

		function void note_matrix(rmq_pkg::matrix_t m);
			pending.push_back(convert(m));
		endfunction

		task check_quat(rmq_pkg::quat_t got);
			rmq_pkg::quat_t want;
			if (pending.size() == 0) begin
				report("unexpected word", 64'(got), 64'd0);
				return;
			end
			want = pending.pop_front();
			checked++;
			case_seen[want.case_taken]++;
			if (want.invalid) invalid_seen++;
			if (got.quat_w !== want.quat_w)
				report("quat_w", 64'(got.quat_w), 64'(want.quat_w));
			if (got.quat_x !== want.quat_x)
				report("quat_x", 64'(got.quat_x), 64'(want.quat_x));
			if (got.quat_y !== want.quat_y)
				report("quat_y", 64'(got.quat_y), 64'(want.quat_y));
			if (got.quat_z !== want.quat_z)
				report("quat_z", 64'(got.quat_z), 64'(want.quat_z));
			if (got.case_taken !== want.case_taken)
				report("case_taken", 64'(got.case_taken), 64'(want.case_taken));
			if (got.invalid !== want.invalid)
				report("invalid", 64'(got.invalid), 64'(want.invalid));
		endtask
	endclass

	quat_scoreboard board = new();
	bit calm = 1'b0;
	bit hold_off = 1'b0;
	bit sending_done = 1'b0;

	initial begin
		matrix_ch.valid = 1'b0;
		matrix_ch.data = '0;
		quat_ch.ready = 1'b0;
	end

	// Accept and check at the rising edge.
	always @(posedge clk) begin
		if (arst_n && matrix_ch.valid && matrix_ch.ready) board.note_matrix(matrix_ch.data);
		if (arst_n && quat_ch.valid && quat_ch.ready) board.check_quat(quat_ch.data);
	end

	// The receiver stalls at random, except while calm or during the long hold-off.
	always @(negedge clk) begin
		if (hold_off) quat_ch.ready <= 1'b0;
		else quat_ch.ready <= calm || ($urandom_range(99) >= 14);
	end

	// Valid stays high between back-to-back words; it drops only while idling.
	task automatic send_matrix(input rmq_pkg::matrix_t m);
		while (!calm && $urandom_range(99) < 14) begin
			matrix_ch.valid <= 1'b0;
			@(negedge clk);
		end
		matrix_ch.data <= m;
		matrix_ch.valid <= 1'b1;
		@(posedge clk);
		while (!matrix_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic rmq_pkg::matrix_t random_matrix();
		rmq_pkg::matrix_t m;
		int pick;
		logic signed [15:0] e[9];
		int one;
		one = 1 << FRAC;
		pick = $urandom_range(3);
		for (int i = 0; i < 9; i++) begin
			case (pick)
				0: e[i] = 16'($urandom);
				1: e[i] = 16'($urandom_range(2 * one) - one);
				default: e[i] = 16'($urandom_range(64) - 32);
			endcase
		end
		// Bias the diagonal so that every branch gets a good share of traffic.
		if (pick >= 2) begin
			case ($urandom_range(3))
				0: begin e[0] = 16'(one - $urandom_range(50)); e[4] = e[0]; e[8] = e[0]; end
				1: begin e[0] = 16'(one - $urandom_range(50)); e[4] = -e[0]; e[8] = -e[0]; end
				2: begin e[4] = 16'(one - $urandom_range(50)); e[0] = -e[4]; e[8] = -e[4]; end
				default: begin
					e[8] = 16'(one - $urandom_range(50)); e[0] = -e[8]; e[4] = -e[8];
				end
			endcase
		end
		m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
		return m;
	endfunction

	initial begin
		rmq_pkg::matrix_t m;
		int one;
		one = 1 << FRAC;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed words: identity, half turns about each axis and extremes.
		send_matrix({16'(one), 16'd0, 16'd0, 16'd0, 16'(one), 16'd0, 16'd0, 16'd0, 16'(one)});
		send_matrix({16'(one), 16'd0, 16'd0, 16'd0, -16'(one), 16'd0, 16'd0, 16'd0, -16'(one)});
		send_matrix({-16'(one), 16'd0, 16'd0, 16'd0, 16'(one), 16'd0, 16'd0, 16'd0, -16'(one)});
		send_matrix({-16'(one), 16'd0, 16'd0, 16'd0, -16'(one), 16'd0, 16'd0, 16'd0, 16'(one)});
		send_matrix({9{16'h7fff}});
		send_matrix({9{16'h8000}});
		send_matrix({9{16'h0000}});
		send_matrix({9{16'hffff}});
		send_matrix({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
			16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
		send_matrix({16'h8000, 16'd0, 16'd0, 16'd0, 16'h7fff, 16'd0, 16'd0, 16'd0, 16'h7fff});
		send_matrix({16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000,
			16'h8000, 16'h8000, 16'h7fff, 16'h8000});
		send_matrix({16'd0, 16'h7fff, 16'h8000, 16'h8000, 16'd0, 16'h7fff,
			16'h7fff, 16'h8000, 16'd0});
		send_matrix({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
			16'h5555, 16'haaaa, 16'h5555});
		send_matrix({-16'd1, 16'd0, 16'd0, 16'd0, -16'd1, 16'd0, 16'd0, 16'd0, -16'd1});
		send_matrix({16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});

		for (int k = 0; k < 1900; k++) begin
			calm = (k >= 600 && k < 900);
			if (k == 1000) begin
				// The sender waits for the whole pipeline to drain.
				matrix_ch.valid <= 1'b0;
				@(negedge clk);
				while (board.pending.size() != 0) @(negedge clk);
			end
			if (k == 1200) begin
				fork
					begin
						hold_off = 1'b1;
						repeat (200) @(negedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			send_matrix(random_matrix());
		end
		matrix_ch.valid <= 1'b0;
		calm = 1'b0;
		@(negedge clk);
		while (board.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		$display("checked %0d quaternions: trace %0d, x %0d, y %0d, z %0d branches",
			board.checked, board.case_seen[0], board.case_seen[1],
			board.case_seen[2], board.case_seen[3]);
		$display("%0d of them with a non-positive radicand", board.invalid_seen);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("timeout");
		$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
